// ===== hdl/odae_pkg.sv =====
// Package for the object dictionary access engine.
// Holds function codes, status codes, kind codes and default sizes; no dependencies.
`timescale 1ns / 1ps
package odae_pkg;
    localparam int TABLE_DEPTH_DEF   = 64;
    localparam int STORE_BYTES_DEF   = 1024;
    localparam int SEGMENT_BYTES_DEF = 8;

    localparam logic [2:0] FN_LOAD   = 3'd0;
    localparam logic [2:0] FN_READ   = 3'd1;
    localparam logic [2:0] FN_WRITE  = 3'd2;
    localparam logic [2:0] FN_EXISTS = 3'd3;
    localparam logic [2:0] FN_GET    = 3'd4;
    localparam logic [2:0] FN_SET    = 3'd5;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_NO_OBJECT  = 3'd1;
    localparam logic [2:0] ST_WRITE_ONLY = 3'd2;
    localparam logic [2:0] ST_READ_ONLY  = 3'd3;
    localparam logic [2:0] ST_NO_DATA    = 3'd4;
    localparam logic [2:0] ST_TOO_LONG   = 3'd5;
    localparam logic [2:0] ST_TOO_SHORT  = 3'd6;

    localparam logic [1:0] KIND_FIXED  = 2'd0;
    localparam logic [1:0] KIND_VSTRING = 2'd1;
endpackage

// ===== hdl/object_dictionary_access_engine_top.sv =====
// Top level of the object dictionary access engine.
// Depends on odae_pkg and odae_ram (key table, attribute table, byte store).
`timescale 1ns / 1ps
//
// Usage: one input word on in_valid/in_ready carries a function code and its
// operands; exactly one result word leaves on out_valid/out_ready for each.
// The user must write the entry_count register through cfg_we/cfg_data
// only while idle; the block does not enforce it. An item is handled one
// at a time. A lookup is a binary search with one table read per probe,
// each probe going through address, RAM read and compare states, and up
// to log2(TABLE_DEPTH)+1 probes; the byte accesses then go one byte at a
// time through the single store port (a read byte takes an address state
// and a capture state, a written byte a write state, and a string
// terminator a further write state). The next word is taken in the cycle
// after the result is handed to the output register.
// One finished result can wait in the output register while the next item
// is worked on; that item then holds in its done state, so a stalled
// receiver blocks the input. Reset clears the state, the output valid
// flag and entry_count; table and store contents are undefined until
// written.
//
module object_dictionary_access_engine_top
    import odae_pkg::*;
#(
    parameter int SEGMENT_BYTES = SEGMENT_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [6:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  func,
    input  logic [5:0]  slot,
    input  logic [15:0] index,
    input  logic [7:0]  sub,
    input  logic [3:0]  access_flags,
    input  logic [1:0]  kind_code,
    input  logic [10:0] object_size,
    input  logic [9:0]  data_base,
    input  logic [10:0] offset,
    input  logic [63:0] data,
    input  logic [3:0]  length,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic        found,
    output logic [63:0] read_data,
    output logic [3:0]  read_length
);
    localparam int TABLE_DEPTH = TABLE_DEPTH_DEF;
    localparam int STORE_BYTES = STORE_BYTES_DEF;
    localparam int TW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int TDP = (TABLE_DEPTH > 1) ? TABLE_DEPTH : 2;
    localparam int CW = $clog2(TABLE_DEPTH + 1) + 1;
    localparam int SW = $clog2(STORE_BYTES);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PROBE = 4'd1;
    localparam logic [3:0] S_PWAIT = 4'd2;
    localparam logic [3:0] S_PCMP  = 4'd3;
    localparam logic [3:0] S_CHECK = 4'd4;
    localparam logic [3:0] S_BRD   = 4'd5;
    localparam logic [3:0] S_BRW   = 4'd6;
    localparam logic [3:0] S_BWR   = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    logic [3:0]  state_reg, state_next;
    logic [6:0]  count_reg;
    logic [2:0]  func_reg;
    logic [23:0] key_reg;
    logic [10:0] off_reg;
    logic [63:0] data_reg;
    logic [3:0]  len_reg;
    logic        last_reg;
    logic signed [CW:0] lo_reg, lo_next, hi_reg, hi_next;
    logic [TW-1:0] mid_reg, mid_next;
    logic [26:0] attr_reg, attr_next;
    logic [3:0]  cnt_reg, cnt_next, tot_reg, tot_next;
    logic        nul_reg, nul_next;
    logic [SW-1:0] addr_reg, addr_next;
    logic [2:0]  st_reg, st_next;
    logic        fd_reg, fd_next;
    logic [63:0] rd_reg, rd_next;
    logic [3:0]  rl_reg, rl_next;

    // Output register that parts the result side from the sequencer.
    logic        ob_valid_reg, ob_valid_next;
    logic        ob_load;
    logic [2:0]  ob_status_reg;
    logic        ob_found_reg;
    logic [63:0] ob_data_reg;
    logic [3:0]  ob_length_reg;

    // Table and store RAMs.
    logic          tab_we;
    logic [TW-1:0] tab_addr;
    logic [23:0]   key_q;
    logic [26:0]   attr_q;
    logic          st_we;
    logic [SW-1:0] st_addr;
    logic [7:0]    st_wdata, st_q;

    odae_ram #(.WIDTH(24), .DEPTH(TDP)) u_key (
        .clk(clk), .we(tab_we), .addr(tab_addr), .wdata({index, sub}), .rdata(key_q));
    odae_ram #(.WIDTH(27), .DEPTH(TDP)) u_attr (
        .clk(clk), .we(tab_we), .addr(tab_addr),
        .wdata({data_base, object_size, kind_code, access_flags}), .rdata(attr_q));
    odae_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_store (
        .clk(clk), .we(st_we), .addr(st_addr), .wdata(st_wdata), .rdata(st_q));

    // Attribute fields of the found entry.
    logic [3:0]  e_flags;
    logic [1:0]  e_kind;
    logic [10:0] e_size;
    logic [9:0]  e_base;
    assign e_flags = attr_reg[3:0];
    assign e_kind  = attr_reg[5:4];
    assign e_size  = attr_reg[16:6];
    assign e_base  = attr_reg[26:17];

    logic [3:0]  seg;
    logic [11:0] seg_end, rem;
    logic [2:0]  gw;
    logic [6:0]  used;
    logic        cmp_eq, cmp_lt;
    logic        accept;
    assign seg = (len_reg > 4'(SEGMENT_BYTES)) ? 4'(SEGMENT_BYTES) : len_reg;
    assign seg_end = {1'b0, off_reg} + 12'(seg);
    assign rem = {1'b0, e_size} - {1'b0, off_reg};
    assign gw = (len_reg == 4'd1 || len_reg == 4'd2) ? len_reg[2:0] : 3'd4;
    assign used = (count_reg > 7'(TABLE_DEPTH)) ? 7'(TABLE_DEPTH) : count_reg;
    assign accept = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);

    // The finished result moves on once the output register is free.
    assign ob_load = (state_reg == S_DONE) && (!ob_valid_reg || out_ready);
    assign ob_valid_next = ob_load || (ob_valid_reg && !out_ready);

    // Key compare for exact key or index-only search.
    always_comb
    begin
        if (func_reg == FN_EXISTS)
        begin
            cmp_eq = key_q[23:8] == key_reg[23:8];
            cmp_lt = key_q[23:8] <  key_reg[23:8];
        end
        else
        begin
            cmp_eq = key_q == key_reg;
            cmp_lt = key_q <  key_reg;
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        lo_next = lo_reg; hi_next = hi_reg; mid_next = mid_reg;
        attr_next = attr_reg; cnt_next = cnt_reg; tot_next = tot_reg;
        nul_next = nul_reg; addr_next = addr_reg;
        st_next = st_reg; fd_next = fd_reg; rd_next = rd_reg; rl_next = rl_reg;
        tab_we = 1'b0; tab_addr = mid_reg;
        st_we = 1'b0; st_addr = addr_reg; st_wdata = 8'd0;
        case (state_reg)
            S_IDLE:
            begin
                tab_addr = slot[TW-1:0];
                if (accept)
                begin
                    st_next = ST_OK; fd_next = 1'b0; rd_next = '0; rl_next = '0;
                    lo_next = '0;
                    hi_next = (CW+1)'($signed({1'b0, CW'(used)}) - 1);
                    if (func == FN_LOAD)
                    begin
                        tab_we = ({26'd0, slot} < 32'(TABLE_DEPTH));
                        state_next = S_DONE;
                    end
                    else if (func <= FN_SET)
                        state_next = S_PROBE;
                    else
                        state_next = S_DONE;
                end
            end
            S_PROBE:
            begin
                if (lo_reg > hi_reg)
                begin
                    st_next = (func_reg == FN_EXISTS) ? ST_OK : ST_NO_OBJECT;
                    state_next = S_DONE;
                end
                else
                begin
                    mid_next = TW'(lo_reg + ((hi_reg - lo_reg) >>> 1));
                    state_next = S_PWAIT;
                end
            end
            S_PWAIT:
                state_next = S_PCMP;
            S_PCMP:
            begin
                if (cmp_eq)
                begin
                    attr_next = attr_q;
                    if (func_reg == FN_EXISTS)
                    begin
                        fd_next = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                        state_next = S_CHECK;
                end
                else
                begin
                    if (cmp_lt)
                        lo_next = (CW+1)'($signed({1'b0, (CW)'(mid_reg)}) + 1);
                    else
                        hi_next = (CW+1)'($signed({1'b0, (CW)'(mid_reg)}) - 1);
                    state_next = S_PROBE;
                end
            end
            S_CHECK:
            begin
                cnt_next = '0; nul_next = 1'b0;
                state_next = S_DONE;
                case (func_reg)
                    FN_READ:
                    begin
                        addr_next = SW'({1'b0, e_base} + {1'b0, off_reg});
                        if (!e_flags[0]) st_next = ST_WRITE_ONLY;
                        else if (!e_flags[3]) st_next = ST_NO_DATA;
                        else if (off_reg > e_size) st_next = ST_TOO_LONG;
                        else
                        begin
                            tot_next = (rem > 12'(seg)) ? seg : rem[3:0];
                            rl_next = tot_next;
                            if (tot_next != 4'd0) state_next = S_BRD;
                        end
                    end
                    FN_WRITE:
                    begin
                        addr_next = SW'({1'b0, e_base} + {1'b0, off_reg});
                        if (!e_flags[1] || e_flags[2]) st_next = ST_READ_ONLY;
                        else if (!e_flags[3]) st_next = ST_NO_DATA;
                        else if (seg_end > {1'b0, e_size}) st_next = ST_TOO_LONG;
                        else if (last_reg && e_kind == KIND_FIXED
                                 && seg_end != {1'b0, e_size})
                            st_next = ST_TOO_SHORT;
                        else
                        begin
                            tot_next = seg;
                            nul_next = last_reg && e_kind == KIND_VSTRING
                                       && seg_end < {1'b0, e_size};
                            if (seg != 4'd0 || nul_next) state_next = S_BWR;
                        end
                    end
                    default:
                    begin
                        addr_next = SW'(e_base);
                        tot_next = {1'b0, gw};
                        if (!e_flags[3]) st_next = ST_NO_DATA;
                        else
                        begin
                            fd_next = 1'b1;
                            if (func_reg == FN_GET)
                            begin
                                rl_next = {1'b0, gw};
                                state_next = S_BRD;
                            end
                            else
                                state_next = S_BWR;
                        end
                    end
                endcase
            end
            S_BRD:
                state_next = S_BRW;
            S_BRW:
            begin
                rd_next = rd_reg | (64'(st_q) << {cnt_reg[2:0], 3'b000});
                cnt_next = cnt_reg + 4'd1;
                addr_next = addr_reg + SW'(1);
                state_next = (cnt_next == tot_reg) ? S_DONE : S_BRD;
            end
            S_BWR:
            begin
                st_we = 1'b1;
                if (cnt_reg == tot_reg)
                begin
                    st_wdata = 8'd0;
                    state_next = S_DONE;
                end
                else
                begin
                    st_wdata = data_reg[{cnt_reg[2:0], 3'b000} +: 8];
                    cnt_next = cnt_reg + 4'd1;
                    addr_next = addr_reg + SW'(1);
                    if (cnt_next == tot_reg && !nul_reg) state_next = S_DONE;
                end
            end
            S_DONE:
                if (ob_load) state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            ob_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ob_valid_reg <= ob_valid_next;
            if (cfg_we) count_reg <= cfg_data;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= func; key_reg <= {index, sub}; off_reg <= offset;
            data_reg <= data; len_reg <= length; last_reg <= last;
        end
        lo_reg <= lo_next; hi_reg <= hi_next; mid_reg <= mid_next;
        attr_reg <= attr_next; cnt_reg <= cnt_next; tot_reg <= tot_next;
        nul_reg <= nul_next; addr_reg <= addr_next;
        st_reg <= st_next; fd_reg <= fd_next; rd_reg <= rd_next; rl_reg <= rl_next;
        if (ob_load)
        begin
            ob_status_reg <= st_reg; ob_found_reg <= fd_reg;
            ob_data_reg <= rd_reg; ob_length_reg <= rl_reg;
        end
    end

    assign out_valid   = ob_valid_reg;
    assign status      = ob_status_reg;
    assign found       = ob_found_reg;
    assign read_data   = ob_data_reg;
    assign read_length = ob_length_reg;
endmodule

// ===== hdl/odae_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module odae_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // One access per cycle; read data registered.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ===== sim/tb_object_dictionary_access_engine_top.sv =====
// Testbench for the object dictionary access engine top level.
// Depends on odae_pkg and the engine RTL; checks every result word against a local predictor or a directed expectation.
`timescale 1ns / 1ps

module tb_object_dictionary_access_engine_top;
    import odae_pkg::*;

    localparam int DEPTH      = 64;
    localparam int BYTES      = 1024;
    localparam int SEG        = 8;
    localparam int CYCLE_CAP  = 1000000;
    localparam int SETTLE     = 60;

    typedef struct {
        logic [2:0]  func;
        logic [5:0]  slot;
        logic [15:0] index;
        logic [7:0]  sub;
        logic [3:0]  flags;
        logic [1:0]  kind;
        logic [10:0] osize;
        logic [9:0]  base;
        logic [10:0] off;
        logic [63:0] data;
        logic [3:0]  len;
        logic        last;
    } req_t;

    typedef struct {
        logic [2:0]  status;
        logic        found;
        logic [63:0] rdata;
        logic [3:0]  rlen;
    } resp_t;

    typedef struct {
        req_t  w;
        bit    typed;
        resp_t r;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [6:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [2:0]  func = '0;
    logic [5:0]  slot = '0;
    logic [15:0] index = '0;
    logic [7:0]  sub = '0;
    logic [3:0]  access_flags = '0;
    logic [1:0]  kind_code = '0;
    logic [10:0] object_size = '0;
    logic [9:0]  data_base = '0;
    logic [10:0] offset = '0;
    logic [63:0] data = '0;
    logic [3:0]  length = '0;
    logic        last = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [2:0]  status;
    logic        found;
    logic [63:0] read_data;
    logic [3:0]  read_length;

    // Mirror of the engine state.
    logic [23:0] key_mirror [DEPTH];
    logic [3:0]  flag_mirror [DEPTH];
    logic [1:0]  kind_mirror [DEPTH];
    logic [10:0] size_mirror [DEPTH];
    logic [9:0]  base_mirror [DEPTH];
    logic [7:0]  store_mirror [BYTES];
    logic [6:0]  count_mirror = '0;

    resp_t pending_resp [$];
    row_t  directed_rows [$];
    int    fail_count = 0;
    int    cycle_count = 0;
    int    words_out = 0;
    int    stall_left = 0;
    bit    quiet = 1'b0;
    bit    squeezed = 1'b0;

    object_dictionary_access_engine_top dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .func(func), .slot(slot),
        .index(index), .sub(sub), .access_flags(access_flags), .kind_code(kind_code),
        .object_size(object_size), .data_base(data_base), .offset(offset),
        .data(data), .length(length), .last(last), .out_valid(out_valid),
        .out_ready(out_ready), .status(status), .found(found),
        .read_data(read_data), .read_length(read_length)
    );

    always #10 clk = ~clk;

    function automatic int used_slots();
        return (count_mirror > DEPTH) ? DEPTH : int'(count_mirror);
    endfunction

    // Binary search for an exact key; returns -1 on a miss.
    function automatic int search_key(logic [23:0] k);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = used_slots() - 1;
        while (lo <= hi) begin
            mid = lo + (hi - lo) / 2;
            if (key_mirror[mid] == k) return mid;
            if (key_mirror[mid] < k) lo = mid + 1;
            else hi = mid - 1;
        end
        return -1;
    endfunction

    // Binary search on the index part of the key only.
    function automatic bit search_index(logic [15:0] ix);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = used_slots() - 1;
        while (lo <= hi) begin
            mid = lo + (hi - lo) / 2;
            if (key_mirror[mid][23:8] == ix) return 1'b1;
            if (key_mirror[mid][23:8] < ix) lo = mid + 1;
            else hi = mid - 1;
        end
        return 1'b0;
    endfunction

    function automatic int byte_addr(int b, int o);
        return (b + o) % BYTES;
    endfunction

    // Applies one word to the mirror and returns the result it should give.
    function automatic resp_t predict_access(req_t w);
        resp_t r;
        int e;
        int seg;
        int n;
        int wid;
        int esize;
        int ebase;
        logic [3:0] ef;
        r = '{ST_OK, 1'b0, 64'd0, 4'd0};
        seg = (w.len > SEG) ? SEG : int'(w.len);
        if (w.func == FN_LOAD) begin
            key_mirror[w.slot]  = {w.index, w.sub};
            flag_mirror[w.slot] = w.flags;
            kind_mirror[w.slot] = w.kind;
            size_mirror[w.slot] = w.osize;
            base_mirror[w.slot] = w.base;
        end else if (w.func == FN_EXISTS) begin
            r.found = search_index(w.index);
        end else if (w.func == FN_READ || w.func == FN_WRITE ||
                     w.func == FN_GET || w.func == FN_SET) begin
            e = search_key({w.index, w.sub});
            if (e < 0) begin
                r.status = ST_NO_OBJECT;
            end else begin
                ef = flag_mirror[e];
                esize = int'(size_mirror[e]);
                ebase = int'(base_mirror[e]);
                if (w.func == FN_READ) begin
                    if (!ef[0]) r.status = ST_WRITE_ONLY;
                    else if (!ef[3]) r.status = ST_NO_DATA;
                    else if (int'(w.off) > esize) r.status = ST_TOO_LONG;
                    else begin
                        n = esize - int'(w.off);
                        if (n > seg) n = seg;
                        for (int i = 0; i < n; i++)
                            r.rdata[8*i +: 8] = store_mirror[byte_addr(ebase, int'(w.off) + i)];
                        r.rlen = n[3:0];
                    end
                end else if (w.func == FN_WRITE) begin
                    if (!ef[1] || ef[2]) r.status = ST_READ_ONLY;
                    else if (!ef[3]) r.status = ST_NO_DATA;
                    else if (int'(w.off) + seg > esize) r.status = ST_TOO_LONG;
                    else if (w.last && kind_mirror[e] == KIND_FIXED &&
                             int'(w.off) + seg != esize) r.status = ST_TOO_SHORT;
                    else begin
                        for (int i = 0; i < seg; i++)
                            store_mirror[byte_addr(ebase, int'(w.off) + i)] = w.data[8*i +: 8];
                        // A short final string segment gets a terminating NUL.
                        if (w.last && kind_mirror[e] == KIND_VSTRING &&
                            int'(w.off) + seg < esize)
                            store_mirror[byte_addr(ebase, int'(w.off) + seg)] = 8'd0;
                    end
                end else begin
                    wid = (w.len == 4'd1 || w.len == 4'd2) ? int'(w.len) : 4;
                    if (!ef[3]) r.status = ST_NO_DATA;
                    else begin
                        r.found = 1'b1;
                        for (int i = 0; i < wid; i++) begin
                            if (w.func == FN_GET)
                                r.rdata[8*i +: 8] = store_mirror[byte_addr(ebase, i)];
                            else
                                store_mirror[byte_addr(ebase, i)] = w.data[8*i +: 8];
                        end
                        if (w.func == FN_GET) r.rlen = wid[3:0];
                    end
                end
            end
        end
        return r;
    endfunction

    function automatic req_t op_word(logic [2:0] f, logic [15:0] ix, logic [7:0] sb,
                                     logic [10:0] o, logic [3:0] n, logic [63:0] d,
                                     logic lst);
        req_t w;
        w = '{f, 6'd0, ix, sb, 4'd0, 2'd0, 11'd0, 10'd0, o, d, n, lst};
        return w;
    endfunction

    function automatic req_t load_word(logic [5:0] s, logic [23:0] k, logic [3:0] fl,
                                       logic [1:0] kd, logic [10:0] sz, logic [9:0] b);
        req_t w;
        w = '{FN_LOAD, s, k[23:8], k[7:0], fl, kd, sz, b, 11'd0, 64'd0, 4'd0, 1'b0};
        return w;
    endfunction

    function automatic logic [23:0] boot_key(int s);
        return {16'h1000 + s[15:0], 8'h01};
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (quiet || p < 50) return 0;
        if (p < 85) return $urandom_range(1, 3);
        if (p < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Offers one word, waits for its acceptance and records the expectation.
    task automatic send_word(req_t w, bit typed, resp_t r);
        int gap;
        resp_t p;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        func <= w.func;
        slot <= w.slot;
        index <= w.index;
        sub <= w.sub;
        access_flags <= w.flags;
        kind_code <= w.kind;
        object_size <= w.osize;
        data_base <= w.base;
        offset <= w.off;
        data <= w.data;
        length <= w.len;
        last <= w.last;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        p = predict_access(w);
        pending_resp.push_back(typed ? r : p);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_resp.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Register write between phases, with the engine idle.
    task automatic set_entry_count(logic [6:0] v);
        drain();
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        count_mirror = v;
    endtask

    // Reloads the whole table with sorted random keys and mostly small objects.
    task automatic rebuild_table();
        logic [23:0] keys [$];
        logic [3:0] fl;
        logic [10:0] sz;
        int p;
        for (int i = 0; i < DEPTH; i++) keys.push_back(24'($urandom()));
        keys.sort();
        for (int i = 0; i < DEPTH; i++) begin
            p = $urandom_range(0, 99);
            fl = (p < 60) ? 4'hB : 4'($urandom());
            sz = (p < 90) ? 11'($urandom_range(0, 24)) : 11'($urandom());
            send_word(load_word(6'(i), keys[i], fl, 2'($urandom()), sz,
                                10'($urandom())), 1'b0, '{ST_OK, 1'b0, 64'd0, 4'd0});
        end
    endtask

    // One random word: mostly lookups of loaded keys, the rest noise.
    task automatic send_random();
        req_t w;
        int p;
        int s;
        int esize;
        p = $urandom_range(0, 99);
        w = op_word(3'($urandom_range(1, 5)), 16'($urandom()), 8'($urandom()),
                    11'd0, 4'($urandom()), {$urandom(), $urandom()}, 1'($urandom()));
        if (p < 8) begin
            w = load_word(6'($urandom()), 24'($urandom()), 4'($urandom()),
                          2'($urandom()), 11'($urandom()), 10'($urandom()));
            if ($urandom_range(0, 1)) w.osize = 11'($urandom_range(0, 24));
        end else if (p < 12) begin
            w.func = 3'($urandom_range(6, 7));
            w.off = 11'($urandom());
        end else if (p < 18) begin
            w.off = 11'($urandom());
        end else begin
            s = $urandom_range(0, (used_slots() > 0) ? used_slots() - 1 : DEPTH - 1);
            w.index = key_mirror[s][23:8];
            w.sub = key_mirror[s][7:0];
            esize = int'(size_mirror[s]);
            w.off = ($urandom_range(0, 19) == 0) ? 11'($urandom())
                                                 : 11'($urandom_range(0, esize + 3));
            if ($urandom_range(0, 3) == 0) w.len = 4'($urandom_range(0, 8));
        end
        send_word(w, 1'b0, '{ST_OK, 1'b0, 64'd0, 4'd0});
    endtask

    task automatic add_row(req_t w, bit typed, resp_t r);
        row_t row;
        row.w = w;
        row.typed = typed;
        row.r = r;
        directed_rows.push_back(row);
    endtask

    // Directed rows that depend on the table filled by the boot sequence.
    task automatic build_rows();
        resp_t z;
        z = '{ST_OK, 1'b0, 64'd0, 4'd0};
        add_row(load_word(6'd60, boot_key(60), 4'hA, KIND_FIXED, 11'd16, 10'd960), 1, z);
        add_row(op_word(FN_READ, 16'h103C, 8'h01, 11'd0, 4'd8, 64'd0, 0), 1,
                '{ST_WRITE_ONLY, 1'b0, 64'd0, 4'd0});
        add_row(load_word(6'd61, boot_key(61), 4'h7, KIND_FIXED, 11'd16, 10'd976), 1, z);
        add_row(op_word(FN_WRITE, 16'h103D, 8'h01, 11'd0, 4'd8, 64'd5, 0), 1,
                '{ST_READ_ONLY, 1'b0, 64'd0, 4'd0});
        add_row(op_word(FN_READ, 16'h103D, 8'h01, 11'd0, 4'd8, 64'd0, 0), 1,
                '{ST_NO_DATA, 1'b0, 64'd0, 4'd0});
        add_row(op_word(FN_GET, 16'h103D, 8'h01, 11'd0, 4'd4, 64'd0, 0), 1,
                '{ST_NO_DATA, 1'b0, 64'd0, 4'd0});
        // A string object that wraps around the end of the store.
        add_row(load_word(6'd62, boot_key(62), 4'hB, KIND_VSTRING, 11'd20, 10'd1020), 1, z);
        add_row(op_word(FN_WRITE, 16'h103E, 8'h01, 11'd0, 4'd4, 64'h4443_4241, 1), 0, z);
        add_row(op_word(FN_READ, 16'h103E, 8'h01, 11'd0, 4'd15, 64'd0, 0), 0, z);
        add_row(op_word(FN_WRITE, 16'h103E, 8'h01, 11'd16, 4'd8, 64'd0, 0), 1,
                '{ST_TOO_LONG, 1'b0, 64'd0, 4'd0});
        add_row(op_word(FN_READ, 16'h103E, 8'h01, 11'd21, 4'd8, 64'd0, 0), 1,
                '{ST_TOO_LONG, 1'b0, 64'd0, 4'd0});
        add_row(op_word(FN_READ, 16'h103E, 8'h01, 11'd20, 4'd8, 64'd0, 0), 1, z);
        add_row(op_word(FN_WRITE, 16'h1000, 8'h01, 11'd0, 4'd8, 64'd1, 1), 1,
                '{ST_TOO_SHORT, 1'b0, 64'd0, 4'd0});
        add_row(op_word(FN_WRITE, 16'h1000, 8'h01, 11'd8, 4'd15, '1, 1), 0, z);
        add_row(op_word(FN_SET, 16'h1000, 8'h01, 11'd0, 4'd2, '1, 0), 0, z);
        add_row(op_word(FN_GET, 16'h1000, 8'h01, 11'd0, 4'd1, 64'd0, 0), 0, z);
        add_row(op_word(FN_GET, 16'h1000, 8'h01, 11'd0, 4'd2, 64'd0, 0), 0, z);
        add_row(op_word(FN_GET, 16'h1000, 8'h01, 11'd0, 4'd0, 64'd0, 0), 0, z);
        add_row(op_word(FN_GET, 16'h1000, 8'h01, 11'd2047, 4'd15, 64'd0, 0), 0, z);
        add_row(op_word(FN_EXISTS, 16'h1005, 8'h00, 11'd0, 4'd0, 64'd0, 0), 1,
                '{ST_OK, 1'b1, 64'd0, 4'd0});
        add_row(op_word(FN_EXISTS, 16'hFFFF, 8'h00, 11'd0, 4'd0, 64'd0, 0), 1, z);
        add_row(op_word(FN_READ, 16'h1005, 8'hFF, 11'd0, 4'd8, 64'd0, 0), 1,
                '{ST_NO_OBJECT, 1'b0, 64'd0, 4'd0});
    endtask

    // Result side: random stalls, one long hold-off, and the field checks.
    always @(posedge clk) begin
        resp_t e;
        int p;
        if (out_valid && out_ready) begin
            words_out++;
            if (pending_resp.size() == 0) begin
                $error("result word with no expectation waiting");
                fail_count++;
            end else begin
                e = pending_resp.pop_front();
                if (status !== e.status) begin
                    $error("status: expected %0d, actual %0d", e.status, status);
                    fail_count++;
                end
                if (found !== e.found) begin
                    $error("found: expected %0d, actual %0d", e.found, found);
                    fail_count++;
                end
                if (read_data !== e.rdata) begin
                    $error("read_data: expected %h, actual %h", e.rdata, read_data);
                    fail_count++;
                end
                if (read_length !== e.rlen) begin
                    $error("read_length: expected %0d, actual %0d", e.rlen, read_length);
                    fail_count++;
                end
            end
        end
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (!squeezed && words_out >= 600) begin
            squeezed <= 1'b1;
            stall_left <= 500;
            out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_ready <= 1'b0;
        end else begin
            p = $urandom_range(0, 99);
            if (quiet || p < 60) out_ready <= 1'b1;
            else if (p < 90) out_ready <= 1'b0;
            else if (p < 98) stall_left <= $urandom_range(2, 10);
            else stall_left <= $urandom_range(20, 60);
        end
    end

    // Watchdog on the total run length.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("object_dictionary_access_engine_top test failed");
            $finish;
        end
    end

    // Stimulus sequence.
    initial begin
        resp_t z;
        logic [6:0] phase_counts [7];
        z = '{ST_OK, 1'b0, 64'd0, 4'd0};
        phase_counts = '{7'd64, 7'd1, 7'd127, 7'd0, 7'd64, 7'd37, 7'd0};
        phase_counts[6] = 7'($urandom_range(2, 127));
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // With no entries in use nothing is found.
        send_word(op_word(FN_EXISTS, 16'h1000, 8'h01, 11'd0, 4'd0, 64'd0, 0), 1, z);
        send_word(op_word(FN_GET, 16'h1000, 8'h01, 11'd0, 4'd4, 64'd0, 0), 1,
                  '{ST_NO_OBJECT, 1'b0, 64'd0, 4'd0});
        send_word(op_word(FN_WRITE, 16'hFFFF, 8'hFF, 11'd0, 4'd8, '1, 1), 1,
                  '{ST_NO_OBJECT, 1'b0, 64'd0, 4'd0});
        send_word(op_word(3'd6, 16'hFFFF, 8'hFF, 11'd2047, 4'd15, '1, 1), 1, z);
        send_word(op_word(3'd7, 16'h1000, 8'h01, 11'd0, 4'd0, 64'd0, 0), 1, z);

        // Boot: load every slot, then fill the whole byte store.
        for (int i = 0; i < DEPTH; i++)
            send_word(load_word(6'(i), boot_key(i), 4'hB, KIND_FIXED, 11'd16,
                                10'(i * 16)), 1, z);
        set_entry_count(7'd64);
        for (int i = 0; i < DEPTH; i++) begin
            send_word(op_word(FN_WRITE, 16'(boot_key(i) >> 8), 8'h01, 11'd0, 4'd8,
                              {$urandom(), $urandom()}, 0), 1, z);
            send_word(op_word(FN_WRITE, 16'(boot_key(i) >> 8), 8'h01, 11'd8, 4'd8,
                              {$urandom(), $urandom()}, 1), 1, z);
        end

        build_rows();
        foreach (directed_rows[i])
            send_word(directed_rows[i].w, directed_rows[i].typed, directed_rows[i].r);

        // Random phases over several entry counts.
        for (int ph = 0; ph < 7; ph++) begin
            set_entry_count(phase_counts[ph]);
            quiet = (ph == 2 || ph == 5);
            rebuild_table();
            for (int n = 0; n < 140; n++) send_random();
        end

        drain();
        if (fail_count == 0)
            $display("object_dictionary_access_engine_top test passed");
        else
            $display("object_dictionary_access_engine_top test failed");
        $finish;
    end

endmodule
